FILE: hdl/normal_map_pixel_patch_macros.svh
// Assertion helpers for the pixel patch block.
// Both expect i_clk in the module that uses them; NPP_ASSERT also expects i_rst_n.
`ifndef NORMAL_MAP_PIXEL_PATCH_MACROS_SVH
`define NORMAL_MAP_PIXEL_PATCH_MACROS_SVH

`ifndef SYNTHESIS

`define NPP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("npp assertion failed");

`define NPP_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("npp reset assertion failed");

`else

`define NPP_ASSERT(lbl, prop)

`define NPP_ASSERT_RST(lbl, prop)

`endif

`endif

FILE: hdl/npp_pkg.sv
`default_nettype none

package npp_pkg;

    localparam int unsigned ChanW   = 8;
    localparam int unsigned SqW     = 16;
    localparam int unsigned RadW    = 16;
    localparam logic [SqW-1:0] UnitSq = 16'd65025;
    localparam int unsigned RootIters = 8;
    localparam int unsigned ItersPerStage = 4;

    typedef enum logic [2:0] {
        MODE_NONE       = 3'd0,
        MODE_BUMP       = 3'd1,
        MODE_EXPAND     = 3'd2,
        MODE_SWZ_EXPAND = 3'd3,
        MODE_STRIP      = 3'd4
    } t_mode;

    // Channels already swizzled; blue is the pass value unless z_en is set.
    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
        logic [ChanW-1:0] alpha;
        logic             z_en;
    } t_ctl;

    typedef struct packed {
        logic [RadW-1:0] rem;
        logic [RadW-1:0] root;
    } t_sq;

    // |2c - 255| for an 8 bit channel
    function automatic logic [ChanW-1:0] abs_signed(input logic [ChanW-1:0] c);
        logic [ChanW-1:0] t;
        t = {c[ChanW-2:0], 1'b1};
        return c[ChanW-1] ? t : ~{c[ChanW-2:0], 1'b0};
    endfunction

    // One restoring square root step; k counts from 0 (top bit pair)
    function automatic t_sq root_step(input t_sq s, input logic [2:0] k);
        t_sq             r;
        logic [RadW-1:0] bitv;
        logic [RadW:0]   sum;
        bitv = RadW'(1) << (4'd14 - {k, 1'b0});
        sum  = {1'b0, s.root} + {1'b0, bitv};
        if ({1'b0, s.rem} >= sum) begin
            r.rem  = s.rem - sum[RadW-1:0];
            r.root = (s.root >> 1) + bitv;
        end else begin
            r.rem  = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/npp_front.sv
`default_nettype none

// Stage 1: swizzle and square the two normal components.
// Stage 2: form the radicand, clamped to zero when not positive.
module npp_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire npp_pkg::t_mode                  i_mode,
    input  wire logic                            i_valid,
    output      logic                            o_ready,
    input  wire logic [npp_pkg::ChanW-1:0]       i_red,
    input  wire logic [npp_pkg::ChanW-1:0]       i_green,
    input  wire logic [npp_pkg::ChanW-1:0]       i_blue,
    input  wire logic [npp_pkg::ChanW-1:0]       i_alpha,
    output      logic                            o_valid,
    input  wire logic                            i_ready,
    output      npp_pkg::t_ctl                   o_ctl,
    output      logic [npp_pkg::RadW-1:0]        o_rad
);

    logic                        r_v1, r_v2;
    npp_pkg::t_ctl               r_ctl1, r_ctl2, n_ctl1;
    logic [npp_pkg::SqW-1:0]     r_sqx, r_sqy;
    logic [npp_pkg::RadW-1:0]    r_rad;
    logic [npp_pkg::ChanW-1:0]   n_cx, n_cy;
    logic [npp_pkg::ChanW-1:0]   ax, ay;
    logic [npp_pkg::SqW+1:0]     diff;
    logic                        rdy1, rdy2;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v2;
    assign o_ctl   = r_ctl2;
    assign o_rad   = r_rad;

    always_comb begin
        n_ctl1 = '{red: i_red, green: i_green, blue: i_blue, alpha: i_alpha, z_en: 1'b0};
        n_cx   = i_red;
        n_cy   = i_green;
        case (i_mode)
            npp_pkg::MODE_BUMP: begin
                n_ctl1.red   = i_alpha;
                n_ctl1.blue  = '1;
                n_ctl1.alpha = '1;
            end
            npp_pkg::MODE_EXPAND: begin
                n_ctl1.z_en = 1'b1;
            end
            npp_pkg::MODE_SWZ_EXPAND: begin
                n_ctl1.red   = i_green;
                n_ctl1.green = i_alpha;
                n_ctl1.alpha = '1;
                n_ctl1.z_en  = 1'b1;
                n_cx         = i_green;
                n_cy         = i_alpha;
            end
            npp_pkg::MODE_STRIP: begin
                n_ctl1.alpha = '1;
            end
            default: begin
            end
        endcase
        ax = npp_pkg::abs_signed(n_cx);
        ay = npp_pkg::abs_signed(n_cy);
    end

    assign diff = {2'b00, npp_pkg::UnitSq} - {2'b00, r_sqx} - {2'b00, r_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
        end
        if (rdy1 && i_valid) begin
            r_ctl1 <= n_ctl1;
            r_sqx  <= npp_pkg::SqW'(ax) * npp_pkg::SqW'(ax);
            r_sqy  <= npp_pkg::SqW'(ay) * npp_pkg::SqW'(ay);
        end
        if (rdy2 && r_v1) begin
            r_ctl2 <= r_ctl1;
            // drop negative radicands to zero, whose root is zero
            r_rad  <= diff[npp_pkg::SqW+1] ? '0 : diff[npp_pkg::RadW-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/npp_root.sv
`default_nettype none

`include "normal_map_pixel_patch_macros.svh"

// Stages 3 and 4: four square root steps each, then the blue merge.
module npp_root (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output      logic                        o_ready,
    input  wire npp_pkg::t_ctl               i_ctl,
    input  wire logic [npp_pkg::RadW-1:0]    i_rad,
    output      logic                        o_valid,
    input  wire logic                        i_ready,
    output      logic [npp_pkg::ChanW-1:0]   o_red,
    output      logic [npp_pkg::ChanW-1:0]   o_green,
    output      logic [npp_pkg::ChanW-1:0]   o_blue,
    output      logic [npp_pkg::ChanW-1:0]   o_alpha
);

    logic            r_v3, r_v4;
    npp_pkg::t_ctl   r_ctl3, r_ctl4, n_ctl4;
    npp_pkg::t_sq    r_sq3, n_sq3, n_sq4;
    logic            rdy3, rdy4;

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign o_ready = rdy3;
    assign o_valid = r_v4;
    assign o_red   = r_ctl4.red;
    assign o_green = r_ctl4.green;
    assign o_blue  = r_ctl4.blue;
    assign o_alpha = r_ctl4.alpha;

    always_comb begin
        n_sq3 = '{rem: i_rad, root: '0};
        for (int k = 0; k < npp_pkg::ItersPerStage; k++) begin
            n_sq3 = npp_pkg::root_step(n_sq3, 3'(k));
        end
        n_sq4 = r_sq3;
        for (int k = npp_pkg::ItersPerStage; k < npp_pkg::RootIters; k++) begin
            n_sq4 = npp_pkg::root_step(n_sq4, 3'(k));
        end
        n_ctl4 = r_ctl3;
        // blue = (nz + 256) >> 1
        if (r_ctl3.z_en) begin
            n_ctl4.blue = {1'b1, n_sq4.root[npp_pkg::ChanW-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy3) r_v3 <= i_valid;
            if (rdy4) r_v4 <= r_v3;
        end
        if (rdy3 && i_valid) begin
            r_ctl3 <= i_ctl;
            r_sq3  <= n_sq3;
        end
        if (rdy4 && r_v3) begin
            r_ctl4 <= n_ctl4;
        end
    end

    `NPP_ASSERT(a_blue_half_up, (r_v4 && r_ctl4.z_en) |-> o_blue[npp_pkg::ChanW-1])
    `NPP_ASSERT(a_out_from_s3, $rose(r_v4) |-> $past(r_v3))
    `NPP_ASSERT(a_stall_full, !rdy3 |-> (r_v3 && r_v4 && !i_ready))
    `NPP_ASSERT_RST(a_reset_empty, !$past(i_rst_n) |-> (!r_v3 && !r_v4))

endmodule

`default_nettype wire

FILE: hdl/normal_map_pixel_patch.sv
`default_nettype none

// RGBA8 pixel patcher. One pixel enters per cycle on i_valid/o_ready and leaves
// on o_valid/i_ready after four register stages: swizzle and squaring, radicand,
// and the two halves of an eight step square root. Throughput stays at one
// pixel per cycle for as long as the sink accepts beats on o_valid/i_ready.
// A stalled sink backs up the pipeline stage by stage, filling empty stages
// first. patch_mode selects: 0 pass-through, 1 bumpmap swizzle, 2 XY expand with
// blue rebuilt as normal Z, 3 swizzled expand (X from green, Y from alpha, alpha
// opaque), 4 alpha strip; codes 5 to 7 pass the pixel through. Rebuilt blue is
// (floor(sqrt(65025 - sx^2 - sy^2)) + 256) >> 1 with s = 2c - 255, so 128 when
// the radicand is not positive. Write patch_mode only with the pipeline empty.
module normal_map_pixel_patch (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output      logic                        o_cfg_ready,
    input  wire logic [2:0]                  i_cfg_patch_mode,
    input  wire logic                        i_valid,
    output      logic                        o_ready,
    input  wire logic [npp_pkg::ChanW-1:0]   i_red_in,
    input  wire logic [npp_pkg::ChanW-1:0]   i_green_in,
    input  wire logic [npp_pkg::ChanW-1:0]   i_blue_in,
    input  wire logic [npp_pkg::ChanW-1:0]   i_alpha_in,
    output      logic                        o_valid,
    input  wire logic                        i_ready,
    output      logic [npp_pkg::ChanW-1:0]   o_red_out,
    output      logic [npp_pkg::ChanW-1:0]   o_green_out,
    output      logic [npp_pkg::ChanW-1:0]   o_blue_out,
    output      logic [npp_pkg::ChanW-1:0]   o_alpha_out
);

    npp_pkg::t_mode             r_patch_mode;
    npp_pkg::t_ctl              mid_ctl;
    logic [npp_pkg::RadW-1:0]   mid_rad;
    logic                       mid_valid, mid_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_patch_mode <= npp_pkg::MODE_NONE;
        end else if (i_cfg_valid) begin
            r_patch_mode <= npp_pkg::t_mode'(i_cfg_patch_mode);
        end
    end

    npp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_patch_mode),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .i_alpha (i_alpha_in),
        .o_valid (mid_valid),
        .i_ready (mid_ready),
        .o_ctl   (mid_ctl),
        .o_rad   (mid_rad)
    );

    npp_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .o_ready (mid_ready),
        .i_ctl   (mid_ctl),
        .i_rad   (mid_rad),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_red   (o_red_out),
        .o_green (o_green_out),
        .o_blue  (o_blue_out),
        .o_alpha (o_alpha_out)
    );

endmodule

`default_nettype wire
